[rtl/tudpf_pkg.sv]
// shared types and constants for the tcp/udp destination port filter
// frame offsets, length limits, protocol codes, table op codes, result record
// no dependencies
package tudpf_pkg;

	// table and frame op codes
	typedef enum logic [1:0] {
		OP_FRAME  = 2'd0,
		OP_MARK   = 2'd1,
		OP_UNMARK = 2'd2
	} op_t;

	// byte offsets within the frame
	localparam logic [5:0] POS_ETYPE_HI = 6'd12;
	localparam logic [5:0] POS_ETYPE_LO = 6'd13;
	localparam logic [5:0] POS_PROTO    = 6'd23;
	localparam logic [5:0] POS_DPORT_HI = 6'd36;
	localparam logic [5:0] POS_DPORT_LO = 6'd37;
	localparam logic [5:0] POS_MAX      = 6'd63;

	// minimum frame lengths
	localparam logic [6:0] LEN_ETH_IP   = 7'd34;
	localparam logic [6:0] LEN_TCP_FULL = 7'd54;
	localparam logic [6:0] LEN_UDP_FULL = 7'd42;

	// header codes
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// one verdict record
	typedef struct packed {
		logic        verdict;
		logic [15:0] seen_port;
	} result_t;

endpackage

[rtl/tcp_udp_dest_port_filter_unit.sv]
// tcp/udp destination port filter: byte parser, blocked port bitmap, verdict queue
// depends on tudpf_pkg
//
// a verdict passes stage 1, then enters the verdict queue, which raises out_valid
// throughput: one transfer per cycle while in_stall is low, frame bytes and table writes alike
// the bitmap is a 1-read 1-write memory of 2^PORT_BITS bits held in 64-bit rows;
// table writes read a row, patch one bit and write it back, forwarded on a row hit
// reset: after arst_n the memory is swept to zero one row a cycle over 2^(PORT_BITS-6)
// rows (1024 at PORT_BITS=16), with in_stall held high meanwhile
module tcp_udp_dest_port_filter_unit #(
	parameter int PORT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             op,
	input  logic [7:0]             frame_byte,
	input  logic                   end_of_frame,
	input  logic [15:0]            table_port,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   verdict,
	output logic [15:0]            seen_port
);

	localparam int WORD_LOG = (PORT_BITS > 6) ? 6 : PORT_BITS - 1;
	localparam int ROW_W    = 1 << WORD_LOG;
	localparam int ROW_AW   = PORT_BITS - WORD_LOG;
	localparam int ROWS     = 1 << ROW_AW;
	localparam int BIT_AW   = (WORD_LOG > 0) ? WORD_LOG : 1;

	// frame parse state
	logic [5:0]  byte_count_q;
	logic [15:0] ether_type_q;
	logic [7:0]  ip_protocol_q;
	logic [15:0] dest_port_q;

	// clearing sweep
	logic              clr_active_q;
	logic [ROW_AW-1:0] clr_row_q;

	// bitmap memory
	logic [ROW_W-1:0] mem [ROWS];
	logic             mem_we;
	logic [ROW_AW-1:0] mem_wa;
	logic [ROW_W-1:0] mem_wd;

	// stage 1
	logic              res_s1;
	logic              wr_s1;
	logic              set_s1;
	logic              look_s1;
	logic [15:0]       seen_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [BIT_AW-1:0] bit_s1;
	logic [ROW_W-1:0]  rd_data_s1;
	logic              fwd_s1;
	logic [ROW_W-1:0]  fwd_data_s1;

	// verdict queue
	logic [1:0]          cnt_q;
	logic                wp_q;
	logic                rp_q;
	tudpf_pkg::result_t  buf_q [2];

	// combinational
	logic                  acc;
	logic                  is_frame;
	logic                  is_tbl;
	logic [15:0]           etype_n;
	logic [7:0]            proto_n;
	logic [15:0]           dport_n;
	logic [6:0]            len;
	logic                  lookup;
	logic                  rd_en;
	logic [PORT_BITS-1:0]  rd_port;
	logic [ROW_AW-1:0]     rd_row;
	logic [BIT_AW-1:0]     rd_bit;
	logic [ROW_W-1:0]      row_cur;
	logic [ROW_W-1:0]      wr_row;
	logic                  pop;
	logic [2:0]            occ;
	tudpf_pkg::result_t    res_n;

	assign acc      = in_valid && !in_stall;
	assign is_frame = acc && (op == tudpf_pkg::OP_FRAME);
	assign is_tbl   = acc && ((op == tudpf_pkg::OP_MARK) || (op == tudpf_pkg::OP_UNMARK));

	// header fields including the byte on the port this cycle
	always_comb begin
		etype_n = ether_type_q;
		proto_n = ip_protocol_q;
		dport_n = dest_port_q;
		if (byte_count_q == tudpf_pkg::POS_ETYPE_HI) etype_n[15:8] = frame_byte;
		if (byte_count_q == tudpf_pkg::POS_ETYPE_LO) etype_n[7:0] = frame_byte;
		if (byte_count_q == tudpf_pkg::POS_PROTO) proto_n = frame_byte;
		if (byte_count_q == tudpf_pkg::POS_DPORT_HI) dport_n[15:8] = frame_byte;
		if (byte_count_q == tudpf_pkg::POS_DPORT_LO) dport_n[7:0] = frame_byte;
	end

	// lookup decision for a frame ending on this byte
	always_comb begin
		len    = {1'b0, byte_count_q} + 7'd1;
		lookup = (len >= tudpf_pkg::LEN_ETH_IP) && (etype_n == tudpf_pkg::ETYPE_IPV4) &&
			(((proto_n == tudpf_pkg::PROTO_TCP) && (len >= tudpf_pkg::LEN_TCP_FULL)) ||
			 ((proto_n == tudpf_pkg::PROTO_UDP) && (len >= tudpf_pkg::LEN_UDP_FULL)));
	end

	// memory read address
	assign rd_en   = is_tbl || (is_frame && end_of_frame && lookup);
	assign rd_port = is_tbl ? table_port[PORT_BITS-1:0] : dport_n[PORT_BITS-1:0];
	assign rd_row  = ROW_AW'(rd_port >> WORD_LOG);
	assign rd_bit  = BIT_AW'(rd_port % ROW_W);

	// frame parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			ether_type_q  <= '0;
			ip_protocol_q <= '0;
			dest_port_q   <= '0;
		end else if (is_frame) begin
			if (end_of_frame) begin
				byte_count_q  <= '0;
				ether_type_q  <= '0;
				ip_protocol_q <= '0;
				dest_port_q   <= '0;
			end else begin
				if (byte_count_q != tudpf_pkg::POS_MAX) byte_count_q <= byte_count_q + 6'd1;
				ether_type_q  <= etype_n;
				ip_protocol_q <= proto_n;
				dest_port_q   <= dport_n;
			end
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_row_q    <= '0;
		end else if (clr_active_q) begin
			clr_row_q <= clr_row_q + ROW_AW'(1);
			if (clr_row_q == ROW_AW'(ROWS - 1)) clr_active_q <= 1'b0;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= 1'b0;
			wr_s1  <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			res_s1 <= is_frame && end_of_frame;
			wr_s1  <= is_tbl;
			fwd_s1 <= rd_en && wr_s1 && (rd_row == row_s1);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		set_s1      <= (op == tudpf_pkg::OP_MARK);
		look_s1     <= lookup;
		seen_s1     <= lookup ? dport_n : 16'd0;
		row_s1      <= rd_row;
		bit_s1      <= rd_bit;
		fwd_data_s1 <= wr_row;
	end

	// row contents with forwarding of the previous write-back
	always_comb begin
		row_cur         = fwd_s1 ? fwd_data_s1 : rd_data_s1;
		wr_row          = row_cur;
		wr_row[bit_s1]  = set_s1;
	end

	// memory write port: sweep or read-modify-write
	assign mem_we = clr_active_q || wr_s1;
	assign mem_wa = clr_active_q ? clr_row_q : row_s1;
	assign mem_wd = clr_active_q ? '0 : wr_row;

	// bitmap memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_data_s1 <= mem[rd_row];
	end

	// verdict record
	always_comb begin
		res_n.verdict   = look_s1 ? row_cur[bit_s1] : 1'b0;
		res_n.seen_port = seen_s1;
	end

	// verdict queue, two entries
	assign out_valid = (cnt_q != 2'd0);
	assign verdict   = buf_q[rp_q].verdict;
	assign seen_port = buf_q[rp_q].seen_port;
	assign pop       = out_valid && !out_stall;
	assign occ       = 3'(cnt_q) + 3'(res_s1);
	assign in_stall  = clr_active_q || (occ >= (3'd2 + 3'(pop)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (res_s1) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(res_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1) buf_q[wp_q] <= res_n;
	end

	// checks
	a_stall_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> in_stall)
		else $error("item accepted during clearing sweep");

	a_no_op_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (!wr_s1 && !res_s1))
		else $error("pipeline busy during clearing sweep");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("verdict queue overflow");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_s1 |=> (cnt_q != 2'd0))
		else $error("verdict lost from queue");

	a_fwd_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> $past(wr_s1))
		else $error("forward without preceding write-back");

endmodule

[verif/testbench.sv]
// self-checking testbench for tcp_udp_dest_port_filter_unit: directed frames, then random traffic
// depends on tudpf_pkg and the filter rtl; verdicts are checked against a built-in port filter model
`timescale 1ns / 1ps

module testbench;

	// op 3 is outside the block's op set and must be ignored
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int RAND_ITEMS = 560;
	localparam int MAX_REPORTS = 10;

	typedef enum {ROW_FRAME, ROW_MARK, ROW_UNMARK, ROW_IGNORED} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		int                 len;
		logic [15:0]        etype;
		logic [7:0]         proto;
		logic [15:0]        port;
		bit                 fixed;
		tudpf_pkg::result_t res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = tudpf_pkg::OP_FRAME;
	logic [7:0]  frame_byte = 8'd0;
	logic        end_of_frame = 1'b0;
	logic [15:0] table_port = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        verdict;
	logic [15:0] seen_port;

	// filter model state
	logic [5:0]  byte_pos = '0;
	logic [15:0] cur_etype = '0;
	logic [7:0]  cur_proto = '0;
	logic [15:0] cur_dport = '0;
	bit          port_blocked [0:65535];

	tudpf_pkg::result_t verdicts_expected [$];
	row_t        plan [$];
	int          idle_mode = 0;
	int          items_sent = 0;
	int          table_writes = 0;
	int          verdicts_due = 0;
	int          verdicts_seen = 0;
	int          drops_seen = 0;
	int          mismatches = 0;
	int          quiet = 0;
	int          stall_left = 0;

	logic [15:0] hot_ports [10] = '{16'd0, 16'd1, 16'd53, 16'd80, 16'd443, 16'h00FF,
		16'hFF00, 16'h8000, 16'h1234, 16'hFFFF};
	int          len_edges [9] = '{1, 13, 14, 33, 34, 41, 42, 53, 54};

	tcp_udp_dest_port_filter_unit #(
		.PORT_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.frame_byte(frame_byte),
		.end_of_frame(end_of_frame),
		.table_port(table_port),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.seen_port(seen_port)
	);

	always #1 clk = ~clk;

	// gap length for either side, shaped by the current idle mode
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (idle_mode == 0)
			return 0;
		if (r < ((idle_mode == 1) ? 65 : 30))
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 3) != 0)
			return hot_ports[$urandom_range(0, 9)];
		return 16'($urandom_range(0, 65535));
	endfunction

	// model of the filter: one transfer in, at most one verdict out
	function automatic void predict_verdict(input logic [1:0] o, input logic [7:0] b,
			input logic last, input logic [15:0] p, output bit got,
			output tudpf_pkg::result_t res);
		logic [5:0] pos;
		logic [6:0] len;
		got = 1'b0;
		res = '0;
		case (o)
			tudpf_pkg::OP_MARK: begin
				port_blocked[p] = 1'b1;
			end
			tudpf_pkg::OP_UNMARK: begin
				port_blocked[p] = 1'b0;
			end
			tudpf_pkg::OP_FRAME: begin
				pos = byte_pos;
				if (pos == tudpf_pkg::POS_ETYPE_HI) cur_etype[15:8] = b;
				if (pos == tudpf_pkg::POS_ETYPE_LO) cur_etype[7:0] = b;
				if (pos == tudpf_pkg::POS_PROTO) cur_proto = b;
				if (pos == tudpf_pkg::POS_DPORT_HI) cur_dport[15:8] = b;
				if (pos == tudpf_pkg::POS_DPORT_LO) cur_dport[7:0] = b;
				if (byte_pos != tudpf_pkg::POS_MAX)
					byte_pos = byte_pos + 6'd1;
				if (last) begin
					// the ethernet length check is implied by the tcp and udp ones
					len = {1'b0, pos} + 7'd1;
					if (cur_etype == tudpf_pkg::ETYPE_IPV4 && len >= tudpf_pkg::LEN_ETH_IP &&
							((cur_proto == tudpf_pkg::PROTO_TCP &&
							len >= tudpf_pkg::LEN_TCP_FULL) ||
							(cur_proto == tudpf_pkg::PROTO_UDP &&
							len >= tudpf_pkg::LEN_UDP_FULL))) begin
						res.seen_port = cur_dport;
						res.verdict = port_blocked[cur_dport];
					end
					got = 1'b1;
					byte_pos = '0;
					cur_etype = '0;
					cur_proto = '0;
					cur_dport = '0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void add_row(row_kind_t kind, int len, logic [15:0] etype,
			logic [7:0] proto, logic [15:0] port, bit fixed, logic v, logic [15:0] seen);
		row_t row;
		row.kind = kind;
		row.len = len;
		row.etype = etype;
		row.proto = proto;
		row.port = port;
		row.fixed = fixed;
		row.res.verdict = v;
		row.res.seen_port = seen;
		plan.push_back(row);
	endfunction

	// one transfer on the input side, then a random gap
	task automatic send_item(input logic [1:0] o, input logic [7:0] b, input logic last,
			input logic [15:0] p, input bit fixed, input tudpf_pkg::result_t fixed_res);
		bit got;
		tudpf_pkg::result_t res;
		int gap;
		in_valid <= 1'b1;
		op <= o;
		frame_byte <= b;
		end_of_frame <= last;
		table_port <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_verdict(o, b, last, p, got, res);
		items_sent++;
		if (o == tudpf_pkg::OP_MARK || o == tudpf_pkg::OP_UNMARK)
			table_writes++;
		if (got) begin
			verdicts_expected.push_back(fixed ? fixed_res : res);
			verdicts_due++;
		end
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// table write or ignored op, used between and inside frames
	task automatic send_side_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_item(tudpf_pkg::OP_MARK, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), pick_port(), 1'b0, '0);
		else if (r < 90)
			send_item(tudpf_pkg::OP_UNMARK, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), pick_port(), 1'b0, '0);
		else
			send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				16'($urandom_range(0, 65535)), 1'b0, '0);
	endtask

	task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
			input logic [15:0] dport, input bit noisy, input bit fixed,
			input tudpf_pkg::result_t fixed_res);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			case (i)
				tudpf_pkg::POS_ETYPE_HI: b = etype[15:8];
				tudpf_pkg::POS_ETYPE_LO: b = etype[7:0];
				tudpf_pkg::POS_PROTO:    b = proto;
				tudpf_pkg::POS_DPORT_HI: b = dport[15:8];
				tudpf_pkg::POS_DPORT_LO: b = dport[7:0];
				default: ;
			endcase
			if (noisy && $urandom_range(0, 99) < 4)
				send_side_op();
			send_item(tudpf_pkg::OP_FRAME, b, i == len - 1, 16'($urandom_range(0, 65535)),
				fixed, fixed_res);
		end
	endtask

	// result side stall pattern
	always @(posedge clk) begin : stall_gen
		int n;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			n = pick_gap();
			out_stall <= (n != 0);
			stall_left <= (n != 0) ? n - 1 : $urandom_range(0, 5);
		end
	end

	// verdict checker
	always @(posedge clk) begin : verdict_check
		tudpf_pkg::result_t want;
		if (out_valid && !out_stall) begin
			verdicts_seen++;
			if (verdict)
				drops_seen++;
			if (verdicts_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected verdict=%0d port=%h", verdict, seen_port);
			end else begin
				want = verdicts_expected.pop_front();
				if (want.verdict !== verdict || want.seen_port !== seen_port) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected verdict=%0d port=%h, got verdict=%0d port=%h",
							want.verdict, want.seen_port, verdict, seen_port);
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", quiet);
			$display("[tcp_udp_dest_port_filter_unit] ERROR");
			$finish;
		end
	end

	initial begin
		int items_goal;
		int r;
		int len;
		logic [15:0] etype;
		logic [7:0] proto;

		// directed frames around every length limit and header case
		add_row(ROW_MARK, 0, '0, '0, 16'd80, 1'b0, 1'b0, 16'd0);
		add_row(ROW_MARK, 0, '0, '0, 16'hFFFF, 1'b0, 1'b0, 16'd0);
		add_row(ROW_MARK, 0, '0, '0, 16'h0000, 1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 1, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 13, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 33, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 53, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 54, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 41, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_UDP, 16'hFFFF,
			1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 42, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_UDP, 16'hFFFF,
			1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 42, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_UDP, 16'h0000,
			1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 60, 16'h86DD, tudpf_pkg::PROTO_TCP, 16'd80, 1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 60, 16'h0008, tudpf_pkg::PROTO_TCP, 16'd80, 1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 60, tudpf_pkg::ETYPE_IPV4, 8'd1, 16'd80, 1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 45, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b1, 1'b0, 16'd0);
		add_row(ROW_FRAME, 64, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd81,
			1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 100, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b0, 1'b0, 16'd0);
		add_row(ROW_IGNORED, 0, '0, '0, 16'd80, 1'b0, 1'b0, 16'd0);
		add_row(ROW_UNMARK, 0, '0, '0, 16'd80, 1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 54, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_TCP, 16'd80,
			1'b0, 1'b0, 16'd0);
		add_row(ROW_FRAME, 64, tudpf_pkg::ETYPE_IPV4, tudpf_pkg::PROTO_UDP, 16'hFFFF,
			1'b0, 1'b0, 16'd0);

		// reset, released at a rising edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_mode = 1;
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_FRAME:
					send_frame(plan[i].len, plan[i].etype, plan[i].proto, plan[i].port, 1'b0,
						plan[i].fixed, plan[i].res);
				ROW_MARK:
					send_item(tudpf_pkg::OP_MARK, 8'hFF, 1'b1, plan[i].port, 1'b0, '0);
				ROW_UNMARK:
					send_item(tudpf_pkg::OP_UNMARK, 8'h00, 1'b0, plan[i].port, 1'b0, '0);
				default:
					send_item(OP_UNUSED, 8'hFF, 1'b1, plan[i].port, 1'b0, '0);
			endcase
		end

		// random traffic: mostly well-formed tcp/udp frames, some malformed ones
		items_goal = items_sent + RAND_ITEMS;
		while (items_sent < items_goal) begin
			r = $urandom_range(0, 99);
			idle_mode = (r < 20) ? 0 : (r < 80) ? 1 : 2;
			repeat ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0)
				send_side_op();
			if ($urandom_range(0, 99) < 75) begin
				proto = $urandom_range(0, 1) ? tudpf_pkg::PROTO_TCP : tudpf_pkg::PROTO_UDP;
				etype = tudpf_pkg::ETYPE_IPV4;
				len = (proto == tudpf_pkg::PROTO_TCP) ? int'(tudpf_pkg::LEN_TCP_FULL)
					: int'(tudpf_pkg::LEN_UDP_FULL);
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(64, 120);
				else
					len = $urandom_range(len, len + 12);
			end else begin
				etype = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
					: tudpf_pkg::ETYPE_IPV4;
				r = $urandom_range(0, 2);
				proto = (r == 0) ? tudpf_pkg::PROTO_TCP : (r == 1) ? tudpf_pkg::PROTO_UDP
					: 8'($urandom_range(0, 255));
				len = $urandom_range(0, 1) ? len_edges[$urandom_range(0, 8)]
					: $urandom_range(1, 60);
			end
			send_frame(len, etype, proto, pick_port(), 1'b1, 1'b0, '0);
		end

		// drain
		in_valid <= 1'b0;
		while (verdicts_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("run covered %0d input transfers, %0d table writes, %0d verdicts (%0d drops)",
			items_sent, table_writes, verdicts_seen, drops_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("[tcp_udp_dest_port_filter_unit] OK");
		else
			$display("[tcp_udp_dest_port_filter_unit] ERROR");
		$finish;
	end

endmodule
